// ===== sv/cswq_pkg.sv =====
// ----------------------------------------------------------------------------
// cswq_pkg
// Types and constants shared by the counting semaphore wait queue: the
// per-semaphore memory word, the per-process link word and the operation codes.
// ----------------------------------------------------------------------------
`default_nettype none

package cswq_pkg;

   localparam int PID_W   = 4;
   localparam int SID_W   = 3;
   localparam int COUNT_W = 6;

   localparam logic signed [COUNT_W-1:0] COUNT_MIN = -6'sd32;
   localparam logic signed [COUNT_W-1:0] COUNT_MAX = 6'sd31;

   typedef enum logic [1:0] {
      KIND_WAIT   = 2'd0,
      KIND_SIGNAL = 2'd1,
      KIND_SET    = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_LINK = 4'b0100,
      ST_DEQ  = 4'b1000
   } state_type;

   typedef struct packed {
      logic signed [COUNT_W-1:0] count;
      logic                      head_valid;
      logic [PID_W-1:0]          head_pid;
      logic [PID_W-1:0]          tail_pid;
   } sem_entry_type;

   typedef struct packed {
      logic             valid;
      logic [PID_W-1:0] pid;
   } link_entry_type;

endpackage

`default_nettype wire

// ===== sv/counting_semaphore_wait_queue.sv =====
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue
// Table of counting semaphores with FIFO wait queues linked through a
// per-process next-link memory; wait, signal and set operations.
// ----------------------------------------------------------------------------
// An item goes from start through the exec state to the rsp_valid strobe, and
// through a further link or dequeue state when a wait appends behind an existing
// waiter or a signal wakes a process: the semaphore word is read, modified and
// written back through one synchronous memory, and the extra state is either the
// second write to the next-link memory (the old tail's link, after the caller's
// own link is cleared) or the registered read of the woken head's link before the
// semaphore word can be written back with the new head.
// busy is high from acceptance until the strobe cycle; a new item may be
// started in the strobe cycle. Each result appears for exactly one cycle
// and cannot be held off by the receiver. No clearing pass after reset.
`default_nettype none

module counting_semaphore_wait_queue
   import cswq_pkg::*;
#(
   parameter int PROC_COUNT = 16,
   parameter int SEM_COUNT  = 8
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic [1:0]                req_kind,
   input  wire logic [SID_W-1:0]          req_sem_id,
   input  wire logic [PID_W-1:0]          req_caller_pid,
   input  wire logic signed [COUNT_W-1:0] req_start_count,
   output logic                           rsp_valid,
   output logic                           rsp_must_block,
   output logic                           rsp_woke_valid,
   output logic [PID_W-1:0]               rsp_woke_pid,
   output logic signed [COUNT_W-1:0]      rsp_count_after
);

   localparam int SEM_AW  = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;
   localparam int LINK_AW = $clog2(PROC_COUNT);

   sem_entry_type  sem_mem [SEM_COUNT];
   link_entry_type link_mem [PROC_COUNT];

   state_type state_ff, state_in;
   logic      accept;

   logic [SEM_COUNT-1:0] sem_vld_ff;
   logic                 sem_hit_ff;
   sem_entry_type        sem_rd_ff;
   link_entry_type       link_rd_ff;

   kind_type                  op_kind_ff;
   logic [SID_W-1:0]          op_sem_ff;
   logic [PID_W-1:0]          op_pid_ff;
   logic signed [COUNT_W-1:0] op_start_ff;

   sem_entry_type    hold_ff;
   logic [PID_W-1:0] old_tail_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_block_ff;
   logic                      rsp_woke_ff;
   logic [PID_W-1:0]          rsp_pid_ff;
   logic signed [COUNT_W-1:0] rsp_count_ff;

   // exec stage
   sem_entry_type             cur;
   sem_entry_type             upd;
   logic                      sem_ok;
   logic                      pid_ok;
   logic                      need_link;
   logic                      need_deq;
   logic                      x_block;
   logic                      x_woke;
   logic [PID_W-1:0]          x_pid;
   logic signed [COUNT_W-1:0] x_count;
   logic signed [COUNT_W-1:0] cnt_dec;
   logic signed [COUNT_W-1:0] cnt_inc;

   // memory ports
   logic              sem_we;
   logic [SEM_AW-1:0] sem_waddr;
   sem_entry_type     sem_wdata;
   logic              link_we;
   logic [LINK_AW-1:0] link_waddr;
   link_entry_type    link_wdata;
   logic [LINK_AW-1:0] link_raddr;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      cur       = sem_hit_ff ? sem_rd_ff : '0;
      upd       = cur;
      sem_ok    = int'(op_sem_ff) < SEM_COUNT;
      pid_ok    = int'(op_pid_ff) < PROC_COUNT;
      need_link = 1'b0;
      need_deq  = 1'b0;
      x_block   = 1'b0;
      x_woke    = 1'b0;
      x_pid     = '0;
      cnt_dec   = (cur.count == COUNT_MIN) ? cur.count : cur.count - 6'sd1;
      cnt_inc   = (cur.count == COUNT_MAX) ? cur.count : cur.count + 6'sd1;
      case (op_kind_ff)
         KIND_WAIT: begin
            if (pid_ok) begin
               upd.count = cnt_dec;
               if (cnt_dec[COUNT_W-1]) begin
                  x_block      = 1'b1;
                  need_link    = cur.head_valid;
                  upd.tail_pid = op_pid_ff;
                  if (!cur.head_valid) begin
                     upd.head_valid = 1'b1;
                     upd.head_pid   = op_pid_ff;
                  end
               end
            end
         end
         KIND_SIGNAL: begin
            upd.count = cnt_inc;
            if ((cnt_inc[COUNT_W-1] || (cnt_inc == '0)) && cur.head_valid) begin
               x_woke   = 1'b1;
               x_pid    = cur.head_pid;
               need_deq = 1'b1;
            end
         end
         KIND_SET: begin
            upd.count = op_start_ff;
         end
         default: begin
            upd = cur;
         end
      endcase
      x_count = upd.count;
      if (!sem_ok) begin
         need_link = 1'b0;
         need_deq  = 1'b0;
         x_block   = 1'b0;
         x_woke    = 1'b0;
         x_pid     = '0;
         x_count   = '0;
      end
   end

   // memory port control
   always_comb begin
      sem_we     = 1'b0;
      sem_waddr  = SEM_AW'(op_sem_ff);
      sem_wdata  = upd;
      link_we    = 1'b0;
      link_waddr = LINK_AW'(op_pid_ff);
      link_wdata = '0;
      link_raddr = LINK_AW'(cur.head_pid);
      case (state_ff)
         ST_EXEC: begin
            sem_we  = sem_ok && !need_deq;
            link_we = sem_ok && x_block;
         end
         ST_LINK: begin
            link_we    = 1'b1;
            link_waddr = LINK_AW'(old_tail_ff);
            link_wdata = '{valid: 1'b1, pid: op_pid_ff};
         end
         ST_DEQ: begin
            sem_we               = 1'b1;
            sem_wdata            = hold_ff;
            sem_wdata.head_valid = link_rd_ff.valid;
            sem_wdata.head_pid   = link_rd_ff.pid;
         end
         default: begin
            sem_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (need_link) begin
               state_in = ST_LINK;
            end else if (need_deq) begin
               state_in = ST_DEQ;
            end else begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         ST_LINK, ST_DEQ: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sem_vld_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (sem_we) sem_vld_ff[sem_waddr] <= 1'b1;
      end
   end

   // semaphore memory
   always_ff @(posedge clock) begin
      if (sem_we) sem_mem[sem_waddr] <= sem_wdata;
      if (accept) begin
         sem_rd_ff  <= sem_mem[SEM_AW'(req_sem_id)];
         sem_hit_ff <= sem_vld_ff[SEM_AW'(req_sem_id)];
      end
   end

   // next-link memory
   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_waddr] <= link_wdata;
      link_rd_ff <= link_mem[link_raddr];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_kind_ff  <= kind_type'(req_kind);
         op_sem_ff   <= req_sem_id;
         op_pid_ff   <= req_caller_pid;
         op_start_ff <= req_start_count;
      end
      if (state_ff == ST_EXEC) begin
         hold_ff      <= upd;
         old_tail_ff  <= cur.tail_pid;
         rsp_block_ff <= x_block;
         rsp_woke_ff  <= x_woke;
         rsp_pid_ff   <= x_pid;
         rsp_count_ff <= x_count;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_must_block  = rsp_block_ff;
   assign rsp_woke_valid  = rsp_woke_ff;
   assign rsp_woke_pid    = rsp_pid_ff;
   assign rsp_count_after = rsp_count_ff;

endmodule

`default_nettype wire
